[hdl/fge_pkg.sv]
// Shared types, request codes and the fire palette of the fire effect grid engine.
package fge_pkg;

  localparam int HEAT_W = 6;
  localparam int COLOR_W = 16;
  localparam int REQ_W = 2;
  localparam int POS_W = 5;

  typedef logic [HEAT_W-1:0] heat_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [REQ_W-1:0] req_t;
  typedef logic [POS_W-1:0] pos_t;

  localparam req_t REQ_IGNITE = 2'd0;
  localparam req_t REQ_COOL   = 2'd1;
  localparam req_t REQ_READ   = 2'd2;

  localparam heat_t HEAT_MAX = 6'd45;

  // Pack one RGB565 color.
  function automatic color_t pal(input logic [4:0] r, input logic [5:0] g,
                                 input logic [4:0] b);
    pal = {r, g, b};
  endfunction

  // Look up the fire color of a heat index; anything above full heat shows as full heat.
  function automatic color_t fire_color(input heat_t h);
    case (h)
      6'd0:  fire_color = pal(5'd0,  6'd0,  5'd0);
      6'd1:  fire_color = pal(5'd2,  6'd0,  5'd0);
      6'd2:  fire_color = pal(5'd4,  6'd0,  5'd0);
      6'd3:  fire_color = pal(5'd6,  6'd0,  5'd0);
      6'd4:  fire_color = pal(5'd8,  6'd0,  5'd0);
      6'd5:  fire_color = pal(5'd10, 6'd0,  5'd0);
      6'd6:  fire_color = pal(5'd12, 6'd0,  5'd0);
      6'd7:  fire_color = pal(5'd14, 6'd0,  5'd0);
      6'd8:  fire_color = pal(5'd16, 6'd0,  5'd0);
      6'd9:  fire_color = pal(5'd18, 6'd0,  5'd0);
      6'd10: fire_color = pal(5'd20, 6'd0,  5'd0);
      6'd11: fire_color = pal(5'd22, 6'd0,  5'd0);
      6'd12: fire_color = pal(5'd24, 6'd0,  5'd0);
      6'd13: fire_color = pal(5'd26, 6'd0,  5'd0);
      6'd14: fire_color = pal(5'd28, 6'd0,  5'd0);
      6'd15: fire_color = pal(5'd30, 6'd0,  5'd0);
      6'd16: fire_color = pal(5'd30, 6'd2,  5'd0);
      6'd17: fire_color = pal(5'd30, 6'd4,  5'd0);
      6'd18: fire_color = pal(5'd30, 6'd8,  5'd0);
      6'd19: fire_color = pal(5'd30, 6'd12, 5'd0);
      6'd20: fire_color = pal(5'd30, 6'd16, 5'd0);
      6'd21: fire_color = pal(5'd30, 6'd20, 5'd0);
      6'd22: fire_color = pal(5'd30, 6'd24, 5'd0);
      6'd23: fire_color = pal(5'd30, 6'd28, 5'd0);
      6'd24: fire_color = pal(5'd30, 6'd32, 5'd0);
      6'd25: fire_color = pal(5'd30, 6'd36, 5'd0);
      6'd26: fire_color = pal(5'd30, 6'd40, 5'd0);
      6'd27: fire_color = pal(5'd30, 6'd44, 5'd0);
      6'd28: fire_color = pal(5'd30, 6'd48, 5'd0);
      6'd29: fire_color = pal(5'd30, 6'd52, 5'd0);
      6'd30: fire_color = pal(5'd30, 6'd60, 5'd0);
      6'd31: fire_color = pal(5'd30, 6'd60, 5'd0);
      6'd32: fire_color = pal(5'd30, 6'd60, 5'd2);
      6'd33: fire_color = pal(5'd30, 6'd60, 5'd4);
      6'd34: fire_color = pal(5'd30, 6'd60, 5'd6);
      6'd35: fire_color = pal(5'd30, 6'd60, 5'd8);
      6'd36: fire_color = pal(5'd30, 6'd60, 5'd10);
      6'd37: fire_color = pal(5'd30, 6'd60, 5'd12);
      6'd38: fire_color = pal(5'd30, 6'd60, 5'd14);
      6'd39: fire_color = pal(5'd30, 6'd60, 5'd16);
      6'd40: fire_color = pal(5'd30, 6'd60, 5'd18);
      6'd41: fire_color = pal(5'd30, 6'd60, 5'd20);
      6'd42: fire_color = pal(5'd30, 6'd60, 5'd22);
      6'd43: fire_color = pal(5'd30, 6'd60, 5'd24);
      6'd44: fire_color = pal(5'd30, 6'd60, 5'd26);
      default: fire_color = pal(5'd30, 6'd60, 5'd30);
    endcase
  endfunction

endpackage

[hdl/fge_ram.sv]
// Generic RAM with one write port and two registered read ports.
module fge_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry and register both reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[hdl/fge_cool_alu.sv]
// Cooling unit: sliding window over the row below and the four-cell average.
module fge_cool_alu (
  input  logic          clk_i,
  input  logic          step_i,
  input  fge_pkg::heat_t below_i,
  input  fge_pkg::heat_t self_i,
  output fge_pkg::heat_t result_o
);
  import fge_pkg::*;

  heat_t win0_q;
  heat_t win1_q;
  logic [HEAT_W+1:0] sum;
  logic [HEAT_W+1:0] dec;

  // Shift the below-row window by one column per step.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      win0_q <= win1_q;
      win1_q <= below_i;
    end
  end

  // Add the four cells, take one off a nonzero sum, divide by four.
  always_comb begin
    sum = {2'b00, win0_q} + {2'b00, win1_q} + {2'b00, below_i} + {2'b00, self_i};
    dec = (sum != '0) ? (sum - {{(HEAT_W+1){1'b0}}, 1'b1}) : sum;
    result_o = dec[HEAT_W+1:2];
  end

endmodule

[hdl/fire_effect_grid_engine.sv]
// Top level of the fire effect grid engine: request sequencer, heat grid and result register.
// Ignite and unused requests: the sequencer goes to the response state, then loads the result register.
// Read requests: registered RAM read, then the result register.
// Cooling pass: rows 1 to GRID_SIZE-2, one cell per cycle through the cooling unit.
// One request at a time; the next transfer is taken once the sequencer is back to idle.
// After reset a clearing pass writes zero to all GRID_SIZE*GRID_SIZE cells, one per cycle,
// before the first transfer is taken.
module fire_effect_grid_engine #(
  parameter int GRID_SIZE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // x_pos [4:0], y_pos [9:5], zero fill
  input  logic [1:0]  s_axis_tuser,  // req_type [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // heat [5:0], pixel_color [21:6], zero fill
);
  import fge_pkg::*;

  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(GRID_SIZE);
  localparam logic [AW-1:0] GA = AW'(GRID_SIZE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] LAST_ROW = CW'(GRID_SIZE - 2);
  localparam logic [CW-1:0] LAST_COL = CW'(GRID_SIZE - 1);
  localparam logic [CW-1:0] FIRST_OUT_COL = CW'(2);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RDWAIT = 3'd2;
  localparam logic [2:0] ST_COOL   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0]    state_q;
  logic [AW-1:0] clr_q;
  logic [CW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic          p_vld_q;
  logic [CW-1:0] p_row_q;
  logic [CW-1:0] p_col_q;
  logic          rd_hit_q;
  heat_t         res_heat_q;
  logic          out_vld_q;
  logic [23:0]   out_data_q;

  req_t          req;
  pos_t          x_pos;
  pos_t          y_pos;
  logic          in_grid;
  logic [AW-1:0] cell_idx;
  logic          accept;
  logic          slot_free;
  logic [AW-1:0] here_addr;
  logic          we;
  logic [AW-1:0] waddr;
  heat_t         wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  heat_t         rdata_a;
  heat_t         rdata_b;
  heat_t         cool_res;
  logic          cool_we;

  // Unpack the request and locate the cell.
  always_comb begin
    req = s_axis_tuser;
    x_pos = s_axis_tdata[4:0];
    y_pos = s_axis_tdata[9:5];
    in_grid = (int'(x_pos) < GRID_SIZE) && (int'(y_pos) < GRID_SIZE);
    cell_idx = AW'(y_pos) * GA + AW'(x_pos);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_vld_q || m_axis_tready;

  // Cooling pass addresses: issue stage reads, process stage writes.
  assign here_addr = AW'(row_q) * GA + AW'(col_q);
  assign cool_we = p_vld_q && (p_col_q >= FIRST_OUT_COL);

  always_comb begin
    raddr_a = (state_q == ST_COOL) ? (here_addr + GA) : cell_idx;
    raddr_b = here_addr - {{(AW-1){1'b0}}, 1'b1};
  end

  // Select the write source: clearing pass, ignite, or cooling result.
  always_comb begin
    we = 1'b0;
    waddr = clr_q;
    wdata = '0;
    if (state_q == ST_CLEAR) begin
      we = 1'b1;
    end else if (cool_we) begin
      we = 1'b1;
      waddr = AW'(p_row_q) * GA + AW'(p_col_q) - {{(AW-1){1'b0}}, 1'b1};
      wdata = cool_res;
    end else if (accept && (req == REQ_IGNITE) && in_grid) begin
      we = 1'b1;
      waddr = cell_idx;
      wdata = HEAT_MAX;
    end
  end

  fge_ram #(
    .WIDTH(HEAT_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  fge_cool_alu u_cool (
    .clk_i   (clk_i),
    .step_i  (p_vld_q),
    .below_i (rdata_a),
    .self_i  (rdata_b),
    .result_o(cool_res)
  );

  // Sequence requests, the cooling pass and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      p_vld_q    <= 1'b0;
      p_row_q    <= '0;
      p_col_q    <= '0;
      rd_hit_q   <= 1'b0;
      res_heat_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      p_vld_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + {{(AW-1){1'b0}}, 1'b1};
          if (clr_q == LAST_ADDR) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_heat_q <= '0;
            rd_hit_q <= (req == REQ_READ) && in_grid;
            if (req == REQ_COOL) begin
              row_q <= CW'(1);
              col_q <= '0;
              state_q <= ST_COOL;
            end else if (req == REQ_READ) begin
              state_q <= ST_RDWAIT;
            end else begin
              state_q <= ST_RESP;
            end
          end
        end
        ST_RDWAIT: begin
          if (rd_hit_q) begin
            res_heat_q <= (rdata_a > HEAT_MAX) ? HEAT_MAX : rdata_a;
          end
          state_q <= ST_RESP;
        end
        ST_COOL: begin
          p_vld_q <= 1'b1;
          p_row_q <= row_q;
          p_col_q <= col_q;
          if (col_q == LAST_COL) begin
            col_q <= '0;
            row_q <= row_q + {{(CW-1){1'b0}}, 1'b1};
            if (row_q == LAST_ROW) begin
              state_q <= ST_DRAIN;
            end
          end else begin
            col_q <= col_q + {{(CW-1){1'b0}}, 1'b1};
          end
        end
        ST_DRAIN: begin
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (slot_free) begin
            out_vld_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Load the result payload when the response leaves the sequencer.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESP) && slot_free) begin
      out_data_q <= {2'b00, fire_color(res_heat_q), res_heat_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = out_data_q;

endmodule
